>>> rtl/at_response_line_parser_top_assert.svh
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef AT_RESPONSE_LINE_PARSER_TOP_ASSERT_SVH
`define AT_RESPONSE_LINE_PARSER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define AT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define AT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/atrlp_pkg.sv
package atrlp_pkg;

  // Receive buffer and line length limits.
  localparam int unsigned RxCapacity = 4096;
  localparam int unsigned LineLimit  = 256;
  localparam int unsigned CountW     = $clog2(RxCapacity + 1);
  localparam int unsigned LenW       = 13;
  localparam int unsigned StatusW    = 10;
  localparam int unsigned KeyCount   = 11;
  localparam int unsigned TextDepth  = 17;
  localparam int unsigned TextW      = 8 * TextDepth;

  // Action codes.
  typedef enum logic [1:0] {
    ActRecv    = 2'd0,
    ActClear   = 2'd1,
    ActRestart = 2'd2
  } action_t;

  // Status word bits; keyword k < 10 sets bit k; KeyReady is a hit index.
  localparam int unsigned StOk     = 0;
  localparam int unsigned StPrompt = 9;
  localparam int unsigned KeyReady = 10;

  // Characters and header sequences.
  localparam logic [7:0]  CharCr  = 8'h0d;
  localparam logic [7:0]  CharLf  = 8'h0a;
  localparam logic [7:0]  CharNul = 8'h00;
  localparam logic [7:0]  CharGt  = ">";
  localparam logic [31:0] HdrList = "+CWL";
  localparam logic [31:0] HdrOkEnd = {"OK", CharCr, CharLf};

  // Keywords, first character in the upper byte so that the newest byte of
  // the text window lines up with the last character.
  localparam logic [15:0]  KwOk       = "OK";
  localparam logic [39:0]  KwError    = "ERROR";
  localparam logic [111:0] KwWifiConn = "WIFI CONNECTED";
  localparam logic [119:0] KwWifiDisc = "WIFI DISCONNECT";
  localparam logic [87:0]  KwGotIp    = "WIFI GOT IP";
  localparam logic [55:0]  KwSendOk   = "SEND OK";
  localparam logic [135:0] KwAlready  = "ALREADY CONNECTED";
  localparam logic [55:0]  KwConnect  = "CONNECT";
  localparam logic [103:0] KwStation  = {"STA", "_CONNECTED"};
  localparam logic [7:0]   KwPrompt   = ">";
  localparam logic [39:0]  KwReady    = "ready";

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    logic       is_recv;
    logic       is_clear;
    logic       is_restart;
    logic       is_nul;
    logic       is_gt;
    logic [7:0] rx_byte;
  } item_t;

  // Keyword hits on the text window (newest byte in bits 7:0), given the
  // receive count including the newest byte.
  function automatic logic [KeyCount-1:0] key_hits(input logic [TextW-1:0] text,
                                                   input logic [CountW-1:0] cnt);
    logic [KeyCount-1:0] hits;
    hits[0]  = (cnt >= CountW'($bits(KwOk) / 8)) &&
               (text[$bits(KwOk)-1:0] == KwOk);
    hits[1]  = (cnt >= CountW'($bits(KwError) / 8)) &&
               (text[$bits(KwError)-1:0] == KwError);
    hits[2]  = (cnt >= CountW'($bits(KwWifiConn) / 8)) &&
               (text[$bits(KwWifiConn)-1:0] == KwWifiConn);
    hits[3]  = (cnt >= CountW'($bits(KwWifiDisc) / 8)) &&
               (text[$bits(KwWifiDisc)-1:0] == KwWifiDisc);
    hits[4]  = (cnt >= CountW'($bits(KwGotIp) / 8)) &&
               (text[$bits(KwGotIp)-1:0] == KwGotIp);
    hits[5]  = (cnt >= CountW'($bits(KwSendOk) / 8)) &&
               (text[$bits(KwSendOk)-1:0] == KwSendOk);
    hits[6]  = (cnt >= CountW'($bits(KwAlready) / 8)) &&
               (text[$bits(KwAlready)-1:0] == KwAlready);
    hits[7]  = (cnt >= CountW'($bits(KwConnect) / 8)) &&
               (text[$bits(KwConnect)-1:0] == KwConnect);
    hits[8]  = (cnt >= CountW'($bits(KwStation) / 8)) &&
               (text[$bits(KwStation)-1:0] == KwStation);
    hits[9]  = (cnt >= CountW'($bits(KwPrompt) / 8)) &&
               (text[$bits(KwPrompt)-1:0] == KwPrompt);
    hits[10] = (cnt >= CountW'($bits(KwReady) / 8)) &&
               (text[$bits(KwReady)-1:0] == KwReady);
    return hits;
  endfunction

endpackage

>>> rtl/atrlp_in_if.sv
interface atrlp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source(output valid, action, rx_byte, input ready);
  modport sink(input valid, action, rx_byte, output ready);
endinterface

>>> rtl/atrlp_out_if.sv
interface atrlp_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  status_flags;
  logic        line_accepted;
  logic        line_dropped;
  logic        stream_done;
  logic        restart_seen;
  logic [12:0] message_length;

  modport source(output valid, status_flags, line_accepted, line_dropped, stream_done,
                 restart_seen, message_length, input ready);
  modport sink(input valid, status_flags, line_accepted, line_dropped, stream_done,
               restart_seen, message_length, output ready);
endinterface

>>> rtl/at_response_line_parser_top.sv
// AT response line parser.
// Input channel "bytes" carries one item per modem event: action 0 delivers
// rx_byte, action 1 clears the status flags, action 2 restarts reception
// after a command is sent; action 3 leaves all state unchanged.
// Output channel "report" returns exactly one item per input item, in order,
// holding the status flags after that item and the per-line pulses
// (line accepted, line dropped, stream done, restart seen) with the length.
// Both channels use valid/ready; an item moves on a clock edge where both
// are high.
// A front stage decodes the action and classifies the byte, a two-entry
// queue decouples it from the back stage, and the back stage updates the
// parser state and loads the output register in the same cycle.
// A result turns valid at the clock edge where the back stage pops its item
// from the queue. Throughput: one item per clock cycle while report.ready
// is high, as the back stage updates its state in the cycle that it pops.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to two more items before bytes.ready drops.
// Synchronous reset (rst high) clears the header window, stream mode, the
// count, the status and match flags, the text window, the queue and the
// output valid.
module at_response_line_parser_top
  import atrlp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  atrlp_in_if.sink    bytes,
  atrlp_out_if.source report
);

  // Front to queue.
  logic  can_push;
  logic  push;
  item_t push_item;

  // Queue to back.
  logic  has_item;
  logic  pop;
  item_t pop_item;

  atrlp_front u_front (
    .bytes     (bytes),
    .can_push  (can_push),
    .push      (push),
    .push_item (push_item)
  );

  atrlp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .can_push  (can_push),
    .pop       (pop),
    .has_item  (has_item),
    .pop_item  (pop_item)
  );

  atrlp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .has_item (has_item),
    .pop_item (pop_item),
    .pop      (pop),
    .report   (report)
  );

endmodule

>>> rtl/atrlp_fifo.sv
module atrlp_fifo
  import atrlp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  can_push,
  input  logic  pop,
  output logic  has_item,
  output item_t pop_item
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign can_push = (count != 2'd2);
  assign has_item = (count != 2'd0);
  assign pop_item = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

`include "at_response_line_parser_top_assert.svh"

  `AT_ASSERT(a_fifo_count_range, count != 2'd3, "queue count out of range")
  `AT_ASSERT_NEXT(a_fifo_hold, !push && !pop, $stable(count) && $stable(rd_ptr), "queue moved without a push or pop")

endmodule

>>> rtl/atrlp_front.sv
module atrlp_front
  import atrlp_pkg::*;
(
  atrlp_in_if.sink bytes,
  input  logic     can_push,
  output logic     push,
  output item_t    push_item
);

  // Decode the action and pre-classify the byte so the back part only
  // handles state.
  assign bytes.ready = can_push;
  assign push        = bytes.valid && can_push;

  always_comb begin
    push_item.is_recv    = (bytes.action == ActRecv);
    push_item.is_clear   = (bytes.action == ActClear);
    push_item.is_restart = (bytes.action == ActRestart);
    push_item.is_nul     = (bytes.rx_byte == CharNul);
    push_item.is_gt      = (bytes.rx_byte == CharGt);
    push_item.rx_byte    = bytes.rx_byte;
  end

endmodule

>>> rtl/atrlp_back.sv
module atrlp_back
  import atrlp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         has_item,
  input  item_t        pop_item,
  output logic         pop,
  atrlp_out_if.source  report
);

  logic [31:0]         header_window;
  logic                stream_mode;
  logic [CountW-1:0]   rx_count;
  logic [StatusW-1:0]  status_word;
  logic [StatusW-1:0]  line_match_flags;
  logic                text_ended;
  logic [TextW-1:0]    recent_text;
  logic                ready_match;

  logic [31:0]         header_window_next;
  logic                stream_mode_next;
  logic [CountW-1:0]   rx_count_next;
  logic [StatusW-1:0]  status_word_next;
  logic [StatusW-1:0]  line_match_flags_next;
  logic                text_ended_next;
  logic [TextW-1:0]    recent_text_next;
  logic                ready_match_next;

  logic                accepted;
  logic                dropped;
  logic                done;
  logic                restart;
  logic [LenW-1:0]     length;

  logic                out_valid;

  assign pop          = has_item && (!out_valid || report.ready);
  assign report.valid = out_valid;

  always_comb begin
    logic [KeyCount-1:0] hits;
    logic [CountW-1:0]   cnt;
    logic                line_end;

    header_window_next    = header_window;
    stream_mode_next      = stream_mode;
    rx_count_next         = rx_count;
    status_word_next      = status_word;
    line_match_flags_next = line_match_flags;
    text_ended_next       = text_ended;
    recent_text_next      = recent_text;
    ready_match_next      = ready_match;
    accepted              = 1'b0;
    dropped               = 1'b0;
    done                  = 1'b0;
    restart               = 1'b0;
    length                = '0;
    hits                  = '0;
    cnt                   = rx_count + CountW'(1);
    line_end              = 1'b0;

    if (pop_item.is_clear) begin
      status_word_next = '0;
    end else if (pop_item.is_restart) begin
      rx_count_next         = '0;
      line_match_flags_next = '0;
      text_ended_next       = 1'b0;
      ready_match_next      = 1'b0;
    end else if (pop_item.is_recv) begin
      header_window_next = {header_window[23:0], pop_item.rx_byte};
      if (header_window_next == HdrList) begin
        stream_mode_next = 1'b1;
      end

      if (rx_count < CountW'(RxCapacity)) begin
        rx_count_next = cnt;

        // Keyword search stops at the first zero byte of the text.
        if (!text_ended) begin
          if (pop_item.is_nul) begin
            text_ended_next = 1'b1;
          end else begin
            recent_text_next      = {recent_text[TextW-9:0], pop_item.rx_byte};
            hits                  = key_hits(recent_text_next, cnt);
            line_match_flags_next = line_match_flags | hits[StatusW-1:0];
            ready_match_next      = ready_match | hits[KeyReady];
          end
        end

        if (pop_item.is_gt) begin
          status_word_next[StPrompt] = 1'b1;
        end

        line_end = (cnt >= CountW'(2)) && (header_window_next[7:0] == CharLf) &&
                   (header_window_next[15:8] == CharCr);

        if (stream_mode_next) begin
          if (header_window_next == HdrOkEnd) begin
            stream_mode_next        = 1'b0;
            status_word_next[StOk]  = 1'b1;
            done                    = 1'b1;
            length                  = LenW'(cnt);
          end
        end else if (line_end) begin
          if (cnt < CountW'(LineLimit)) begin
            accepted         = 1'b1;
            length           = LenW'(cnt);
            status_word_next = status_word_next | line_match_flags_next;
            if (ready_match_next) begin
              status_word_next = '0;
              length           = '0;
              restart          = 1'b1;
            end
          end else begin
            dropped = 1'b1;
          end
          rx_count_next         = '0;
          line_match_flags_next = '0;
          text_ended_next       = 1'b0;
          ready_match_next      = 1'b0;
        end
      end else begin
        // Buffer full: the byte is dropped and reception starts over.
        rx_count_next         = '0;
        line_match_flags_next = '0;
        text_ended_next       = 1'b0;
        ready_match_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_window    <= '0;
      stream_mode      <= 1'b0;
      rx_count         <= '0;
      status_word      <= '0;
      line_match_flags <= '0;
      text_ended       <= 1'b0;
      recent_text      <= '0;
      ready_match      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        header_window    <= header_window_next;
        stream_mode      <= stream_mode_next;
        rx_count         <= rx_count_next;
        status_word      <= status_word_next;
        line_match_flags <= line_match_flags_next;
        text_ended       <= text_ended_next;
        recent_text      <= recent_text_next;
        ready_match      <= ready_match_next;
        out_valid        <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      report.status_flags   <= status_word_next;
      report.line_accepted  <= accepted;
      report.line_dropped   <= dropped;
      report.stream_done    <= done;
      report.restart_seen   <= restart;
      report.message_length <= length;
    end
  end

`include "at_response_line_parser_top_assert.svh"

  `AT_ASSERT(a_count_bound, rx_count <= CountW'(RxCapacity), "receive count beyond capacity")
  `AT_ASSERT(a_restart_clears, !(out_valid && report.restart_seen) || (report.status_flags == '0 && report.message_length == '0), "restart result not cleared")
  `AT_ASSERT_NEXT(a_stream_ends, pop && done, !stream_mode && status_word[StOk], "stream end did not leave stream mode")
  `AT_ASSERT_NEXT(a_stall_holds, out_valid && !report.ready, out_valid, "result lost while stalled")

endmodule
